@@ design/loco_med_predictor_bias_ctx_core_assert.svh @@
// Assertion macros for the LOCO MED predictor core.
// Included by the top level; needs no package.
`ifndef LOCO_MED_PREDICTOR_BIAS_CTX_CORE_ASSERT_SVH
`define LOCO_MED_PREDICTOR_BIAS_CTX_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define LMPB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");
// Next-cycle implication, checked out of reset.
`define LMPB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication failed");
`else
`define LMPB_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LMPB_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ design/lmpb_pkg.sv @@
// Shared types, constants and helper functions of the LOCO MED predictor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lmpb_pkg;

   localparam int LINE_DEPTH = 1024;
   localparam int COL_W      = $clog2(LINE_DEPTH);
   localparam int WIDTH_W    = COL_W + 1;
   localparam int NUM_CTX    = 365;
   localparam int CTX_W      = $clog2(NUM_CTX);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = WIDTH_W;

   localparam logic [CSR_IDX_W-1:0] CSR_DECODE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH = 2'd1;

   typedef struct packed {
      logic        [6:0] count;
      logic signed [6:0] bias;
      logic signed [7:0] corr;
   } ctx_entry_type;

   localparam ctx_entry_type CTX_RESET = '{count: 7'd1, bias: 7'sd0, corr: 8'sd0};

   // quantize a gradient to nine levels
   function automatic logic signed [3:0] quant_grad(input logic signed [8:0] g);
      logic signed [3:0] q;
      if (g <= -9'sd21)      q = -4'sd4;
      else if (g <= -9'sd7)  q = -4'sd3;
      else if (g <= -9'sd3)  q = -4'sd2;
      else if (g < 9'sd0)    q = -4'sd1;
      else if (g == 9'sd0)   q = 4'sd0;
      else if (g < 9'sd3)    q = 4'sd1;
      else if (g < 9'sd7)    q = 4'sd2;
      else if (g < 9'sd21)   q = 4'sd3;
      else                   q = 4'sd4;
      return q;
   endfunction

   function automatic logic [2:0] act_class(input logic [9:0] s);
      logic [2:0] k;
      if (s <= 10'd1)       k = 3'd0;
      else if (s <= 10'd3)  k = 3'd1;
      else if (s <= 10'd8)  k = 3'd2;
      else if (s <= 10'd14) k = 3'd3;
      else if (s <= 10'd29) k = 3'd4;
      else if (s <= 10'd61) k = 3'd5;
      else                  k = 3'd6;
      return k;
   endfunction

   function automatic logic [7:0] abs8(input logic signed [7:0] v);
      return v[7] ? 8'(-v) : 8'(v);
   endfunction

endpackage
`default_nettype wire

@@ design/loco_med_predictor_bias_ctx_core.sv @@
// LOCO-I MED predictor with JPEG-LS bias correction, encode and decode.
// Each accepted item passes through the stage 1 registers, stage 2 registers and result register.
// Throughput: one item per cycle when not stalled; the context read-modify-write loop closes in stage 2.
// Reset: synchronous; after reset, and before a frame_start item that follows other items,
// a sweep over all 365 contexts rewrites the context memory while req_ready stays low.
// Depends on lmpb_pkg and loco_med_predictor_bias_ctx_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "loco_med_predictor_bias_ctx_core_assert.svh"
module loco_med_predictor_bias_ctx_core (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  [7:0]                       req_sample,
   input  wire                              req_frame_start,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [7:0]                       rsp_pixel,
   output logic signed [7:0]                rsp_residual,
   output logic [7:0]                       rsp_prediction,
   output logic [2:0]                       rsp_activity_class,
   input  wire                              csr_wr_en,
   input  wire  [lmpb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [lmpb_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import lmpb_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   // configuration
   logic               decode_mode_ff;
   logic [WIDTH_W-1:0] image_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff <= 1'b0;
         image_width_ff <= WIDTH_W'(LINE_DEPTH);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DECODE_MODE: decode_mode_ff <= csr_wr_data[0];
            CSR_IMAGE_WIDTH: image_width_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // pipeline advance: whole pipe moves when the result register can take an item
   logic en;
   logic accept;
   assign en     = !rsp_valid || rsp_ready;
   assign accept = req_valid && req_ready;

   // context sweep control
   state_type      st_ff, st_in;
   logic [CTX_W-1:0] clr_addr_ff, clr_addr_in;
   logic           clr_done_ff, clr_done_in;
   logic           s1_valid_ff, s2_valid_ff;

   always_comb begin
      st_in       = st_ff;
      clr_addr_in = clr_addr_ff;
      clr_done_in = clr_done_ff;
      case (st_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == CTX_W'(NUM_CTX - 1)) begin
               st_in       = ST_RUN;
               clr_done_in = 1'b1;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_RUN: begin
            // wait for the pipe to drain so no context write races the sweep
            if (req_valid && req_frame_start && !clr_done_ff && !s1_valid_ff && !s2_valid_ff) begin
               st_in       = ST_CLEAR;
               clr_addr_in = '0;
            end
            // any accepted item may touch the contexts
            if (accept) clr_done_in = 1'b0;
         end
         default: st_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_CLEAR;
         clr_addr_ff <= '0;
         clr_done_ff <= 1'b0;
      end else begin
         st_ff       <= st_in;
         clr_addr_ff <= clr_addr_in;
         clr_done_ff <= clr_done_in;
      end
   end

   assign req_ready = en && (st_ff == ST_RUN) && !(req_frame_start && !clr_done_ff);

   // raster position, advanced at accept
   logic [COL_W-1:0]   column_ff;
   logic               first_row_ff;
   logic [WIDTH_W-1:0] width_eff;
   logic [COL_W-1:0]   x_new;
   logic [WIDTH_W-1:0] x_next;
   logic               first_row_new;

   always_comb begin
      if (image_width_ff == '0)                         width_eff = WIDTH_W'(1);
      else if (image_width_ff > WIDTH_W'(LINE_DEPTH))   width_eff = WIDTH_W'(LINE_DEPTH);
      else                                              width_eff = image_width_ff;
      x_new         = req_frame_start ? '0 : column_ff;
      first_row_new = req_frame_start ? 1'b1 : first_row_ff;
      x_next        = {1'b0, x_new} + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         first_row_ff <= 1'b1;
      end else if (accept) begin
         if (x_next >= width_eff) begin
            column_ff    <= '0;
            first_row_ff <= 1'b0;
         end else begin
            column_ff    <= x_next[COL_W-1:0];
            first_row_ff <= first_row_new;
         end
      end
   end

   // stage-2 results used for forwarding (declared ahead)
   logic [7:0]        cur2;
   logic [7:0]        res2;
   logic [COL_W-1:0]  s2_x_ff;
   logic              s2_fs_ff;
   logic [15:0]       s2_b_ff;
   logic [CTX_W-1:0]  s2_ctx_ff;
   ctx_entry_type     upd_entry;

   // line store: {pixel, residual} per column, two read ports, one write port
   logic [15:0] line_mem [LINE_DEPTH];
   logic [15:0] line_b_q, line_d_q;
   logic        line_we;
   assign line_we = s2_valid_ff && en;

   always_ff @(posedge clock) begin
      if (line_we) line_mem[s2_x_ff] <= {cur2, res2};
      if (accept) begin
         line_b_q <= line_mem[x_new];
         line_d_q <= line_mem[x_next[COL_W-1:0]];
      end
   end

   // stage 1 registers
   logic [7:0]       s1_sample_ff;
   logic             s1_fs_ff, s1_mode_ff, s1_first_row_ff, s1_at_left_ff, s1_has_right_ff;
   logic [COL_W-1:0] s1_x_ff;
   logic             s1_wb_hit_ff, s1_wd_hit_ff;
   logic [15:0]      s1_w_data_ff;
   logic             w_ok;

   // the item written at this edge may serve the new item unless a newer frame began
   assign w_ok = s2_valid_ff && !req_frame_start && !(s1_valid_ff && s1_fs_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff    <= req_sample;
         s1_fs_ff        <= req_frame_start;
         s1_mode_ff      <= decode_mode_ff;
         s1_x_ff         <= x_new;
         s1_first_row_ff <= first_row_new;
         s1_at_left_ff   <= (x_new == '0);
         s1_has_right_ff <= x_next < width_eff;
         s1_wb_hit_ff    <= w_ok && (s2_x_ff == x_new);
         s1_wd_hit_ff    <= w_ok && (s2_x_ff == x_next[COL_W-1:0]);
         s1_w_data_ff    <= {cur2, res2};
      end
   end

   // neighbour state, updated as each item retires from stage 2
   logic [15:0]      left_ff;
   logic [15:0]      ul_ff;
   logic [WIDTH_W-1:0] fill_ff;
   logic [WIDTH_W-1:0] s2_x_next;
   assign s2_x_next = {1'b0, s2_x_ff} + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         ul_ff   <= '0;
         fill_ff <= '0;
      end else if (line_we) begin
         left_ff <= {cur2, res2};
         ul_ff   <= s2_b_ff;
         if (s2_fs_ff || s2_x_next > fill_ff) fill_ff <= s2_x_next;
      end
   end

   // stage 1 logic: neighbours with forwarding, context, MED, activity class
   logic [COL_W-1:0] s1_xd;
   logic             s2_hit_b, s2_hit_d, mem_ok_b, mem_ok_d;
   logic [15:0]      nb_b, nb_d, nb_a, nb_c;
   logic [7:0]       pa, pb, pc, pd;
   logic signed [3:0] q1, q2, q3;
   logic             neg1;
   logic signed [9:0] ctx_raw;
   logic [CTX_W-1:0] ctx1;
   logic [7:0]       mx, mn, med1;
   logic [9:0]       act_sum;
   logic [2:0]       cls1;

   always_comb begin
      s1_xd    = s1_x_ff + 1'b1;
      s2_hit_b = s2_valid_ff && (s2_x_ff == s1_x_ff) && !s1_fs_ff;
      s2_hit_d = s2_valid_ff && (s2_x_ff == s1_xd) && !s1_fs_ff;
      mem_ok_b = ({1'b0, s1_x_ff} < fill_ff) && !(s2_valid_ff && s2_fs_ff);
      mem_ok_d = ({1'b0, s1_xd} < fill_ff) && !(s2_valid_ff && s2_fs_ff);

      if (s1_first_row_ff)   nb_b = '0;
      else if (s2_hit_b)     nb_b = {cur2, res2};
      else if (s1_wb_hit_ff) nb_b = s1_w_data_ff;
      else if (mem_ok_b)     nb_b = line_b_q;
      else                   nb_b = '0;

      if (s1_first_row_ff || !s1_has_right_ff) nb_d = '0;
      else if (s2_hit_d)     nb_d = {cur2, res2};
      else if (s1_wd_hit_ff) nb_d = s1_w_data_ff;
      else if (mem_ok_d)     nb_d = line_d_q;
      else                   nb_d = '0;

      if (s1_at_left_ff)     nb_a = '0;
      else if (s2_valid_ff)  nb_a = {cur2, res2};
      else                   nb_a = left_ff;

      if (s1_at_left_ff || s1_first_row_ff) nb_c = '0;
      else if (s2_valid_ff)  nb_c = s2_b_ff;
      else                   nb_c = ul_ff;

      pa = nb_a[15:8];
      pb = nb_b[15:8];
      pc = nb_c[15:8];
      pd = nb_d[15:8];

      q1 = quant_grad($signed({1'b0, pd}) - $signed({1'b0, pb}));
      q2 = quant_grad($signed({1'b0, pb}) - $signed({1'b0, pc}));
      q3 = quant_grad($signed({1'b0, pc}) - $signed({1'b0, pa}));
      neg1 = (q1 < 0) || (q1 == 0 && q2 < 0) || (q1 == 0 && q2 == 0 && q3 < 0);
      ctx_raw = 10'(q1 * 81 + q2 * 9 + q3);
      ctx1 = neg1 ? CTX_W'(-ctx_raw) : CTX_W'(ctx_raw);

      mx = (pa > pb) ? pa : pb;
      mn = (pa < pb) ? pa : pb;
      if (pc >= mx)      med1 = mn;
      else if (pc <= mn) med1 = mx;
      else               med1 = 8'({1'b0, pa} + {1'b0, pb} - {1'b0, pc});

      act_sum = 10'(abs8(nb_a[7:0])) + 10'(abs8(nb_b[7:0]))
              + 10'(abs8(nb_c[7:0])) + 10'(abs8(nb_d[7:0]));
      cls1 = act_class(act_sum);
   end

   // context memory: sweep or stage-2 write, stage-1 read with bypass of the
   // entry being written in the same cycle
   ctx_entry_type    ctx_mem [NUM_CTX];
   ctx_entry_type    ctx_q;
   ctx_entry_type    ctx_byp_ff;
   logic             ctx_byp_hit_ff;
   logic             ctx_we_run, ctx_we;
   logic [CTX_W-1:0] ctx_waddr;
   ctx_entry_type    ctx_wdata;

   assign ctx_we_run = s2_valid_ff && en && (s2_ctx_ff != '0);
   assign ctx_we     = ctx_we_run || (st_ff == ST_CLEAR);
   assign ctx_waddr  = (st_ff == ST_CLEAR) ? clr_addr_ff : s2_ctx_ff;
   assign ctx_wdata  = (st_ff == ST_CLEAR) ? CTX_RESET : upd_entry;

   always_ff @(posedge clock) begin
      if (ctx_we) ctx_mem[ctx_waddr] <= ctx_wdata;
      if (en) begin
         ctx_q          <= ctx_mem[ctx1];
         ctx_byp_hit_ff <= ctx_we_run && (s2_ctx_ff == ctx1);
         ctx_byp_ff     <= upd_entry;
      end
   end

   // stage 2 registers
   logic [7:0] s2_sample_ff, s2_med_ff;
   logic       s2_mode_ff, s2_neg_ff;
   logic [2:0] s2_cls_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_sample_ff <= s1_sample_ff;
         s2_fs_ff     <= s1_fs_ff;
         s2_mode_ff   <= s1_mode_ff;
         s2_x_ff      <= s1_x_ff;
         s2_b_ff      <= nb_b;
         s2_neg_ff    <= neg1;
         s2_med_ff    <= med1;
         s2_ctx_ff    <= ctx1;
         s2_cls_ff    <= cls1;
      end
   end

   // stage 2 logic: corrected prediction, residual, context update
   ctx_entry_type      ent;
   logic signed [9:0]  pred_w;
   logic [7:0]         pred2;
   logic signed [8:0]  err, err_s;
   logic signed [10:0] bsum;
   logic [6:0]         cnt;
   logic signed [8:0]  corr_w;
   logic signed [10:0] cnt_s;

   always_comb begin
      ent    = ctx_byp_hit_ff ? ctx_byp_ff : ctx_q;
      pred_w = $signed({2'b0, s2_med_ff}) + (s2_neg_ff ? -10'(ent.corr) : 10'(ent.corr));
      if (pred_w < 0)             pred2 = 8'd0;
      else if (pred_w > 10'sd255) pred2 = 8'd255;
      else                        pred2 = pred_w[7:0];

      if (s2_mode_ff) begin
         res2 = s2_sample_ff;
         cur2 = pred2 + s2_sample_ff;
      end else begin
         cur2 = s2_sample_ff;
         res2 = s2_sample_ff - pred2;
      end
      err   = $signed({1'b0, cur2}) - $signed({1'b0, pred2});
      err_s = s2_neg_ff ? -err : err;

      // bias update with halving at count 64
      bsum = 11'(ent.bias) + 11'(err_s);
      cnt  = ent.count;
      if (ent.count >= 7'd64) begin
         bsum = bsum >>> 1;
         cnt  = ent.count >> 1;
      end
      cnt    = cnt + 1'b1;
      cnt_s  = $signed({4'b0, cnt});
      corr_w = 9'(ent.corr);
      if (bsum <= -cnt_s) begin
         corr_w = corr_w - 9'sd1;
         bsum   = bsum + cnt_s;
         if (bsum <= -cnt_s) bsum = 11'sd1 - cnt_s;
      end else if (bsum > 0) begin
         corr_w = corr_w + 9'sd1;
         bsum   = bsum - cnt_s;
         if (bsum > 0) bsum = '0;
      end
      if (corr_w < -9'sd128)     corr_w = -9'sd128;
      else if (corr_w > 9'sd127) corr_w = 9'sd127;
      upd_entry.count = cnt;
      upd_entry.bias  = 7'(bsum);
      upd_entry.corr  = 8'(corr_w);
   end

   // result register: holds the item while the consumer stalls
   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_pixel          <= cur2;
         rsp_residual       <= $signed(res2);
         rsp_prediction     <= pred2;
         rsp_activity_class <= s2_cls_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // checks
   `LMPB_ASSERT_IMP(a_sweep_pipe_empty, clock, reset, st_ff == ST_CLEAR, !s1_valid_ff && !s2_valid_ff && !accept)
   `LMPB_ASSERT_IMP(a_ctx_write_run, clock, reset, ctx_we_run, st_ff == ST_RUN)
   `LMPB_ASSERT_IMP(a_frame_start_pos, clock, reset, s1_valid_ff && s1_fs_ff, s1_at_left_ff && s1_first_row_ff)
   `LMPB_ASSERT_NXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(s2_valid_ff))

endmodule
`default_nettype wire
